// ===== hw/rtl/bep_pkg.sv =====
package bep_pkg;

    // Frame layout
    localparam logic [8:0] BSSID_FIRST   = 9'd10;
    localparam logic [8:0] BSSID_LAST    = 9'd15;
    localparam logic [8:0] CAP_LOW       = 9'd34;
    localparam logic [8:0] CAP_HIGH      = 9'd35;
    localparam logic [8:0] ELEMENT_BASE  = 9'd36;
    localparam logic [8:0] FRAME_WINDOW  = 9'd112;
    localparam logic [7:0] NAME_MAX      = 8'd32;
    localparam logic [7:0] OFFSET_MAX    = 8'd255;

    // Element ids
    localparam logic [7:0] ID_SSID       = 8'h00;
    localparam logic [7:0] ID_CHANNEL    = 8'h03;

    // Name store geometry: two banks of four 64-bit rows
    localparam int STORE_BYTES = 32;
    localparam int ROW_BYTES   = 8;
    localparam int ROW_BITS    = ROW_BYTES * 8;
    localparam int IDX_W       = 5;
    localparam int LANE_W      = 3;
    localparam int ROW_W       = 2;
    localparam int RAM_AW      = ROW_W + 1;
    localparam int RAM_DEPTH   = 2 * (STORE_BYTES / ROW_BYTES);

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_CHUNK   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_TOO_LONG     = 2'd1,
        STATUS_NO_SSID_FIRST = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]        frame_byte;
        logic signed [7:0] signal_strength;
        logic              frame_end;
    } t_in_beat;

    typedef struct packed {
        logic              result_kind;
        logic [47:0]       access_point_id;
        logic [15:0]       capability_word;
        logic [7:0]        radio_channel;
        logic [7:0]        name_length;
        t_status           parse_status;
        logic signed [7:0] frame_strength;
        logic [63:0]       name_chunk;
        logic [1:0]        chunk_number;
        logic              run_last;
    } t_out_beat;

    // One RAM access request
    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } t_ram_req;

    // Frame summary handed from the parser to the result sequencer
    typedef struct packed {
        logic                   load;
        logic                   bank;
        logic [47:0]            bssid;
        logic [15:0]            capability;
        logic [7:0]             channel;
        logic [7:0]             name_length;
        t_status                status;
        logic signed [7:0]      strength;
        logic [STORE_BYTES-1:0] valid;
    } t_handoff;

endpackage

// ===== hw/rtl/bep_ram.sv =====
module bep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one row, read two rows with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ===== hw/rtl/bep_run.sv =====
module bep_run (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bep_pkg::t_handoff    i_hand,
    input  bep_pkg::t_ram_req    i_wr,
    output logic                 o_busy,
    output bep_pkg::t_ram_req    o_rd,
    input  logic [63:0]          i_rdata,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bep_pkg::t_out_beat   o_data
);
    import bep_pkg::*;

    localparam logic [2:0] STEP_SUMMARY = 3'd0;
    localparam logic [2:0] STEP_LAST    = 3'd4;

    logic              r_busy;
    logic [2:0]        r_step;
    t_handoff          r_hand;
    logic              r_valid;
    t_out_beat         r_data;
    t_out_beat         n_data;
    logic              out_free;
    logic              hold;
    logic              load;
    logic [2:0]        step_m1;
    logic [ROW_W-1:0]  row;

    assign out_free = !r_valid || i_ready;
    // Hold the summary while the frame's last store write is still in flight
    assign hold     = i_wr.en && (i_wr.addr[RAM_AW-1] == r_hand.bank);
    assign load     = r_busy && out_free && !((r_step == STEP_SUMMARY) && hold);
    assign step_m1  = r_step - 3'd1;
    assign row      = step_m1[ROW_W-1:0];

    // Fetch the row for the next beat as the current one is loaded
    assign o_rd.en   = load && (r_step != STEP_LAST);
    assign o_rd.addr = {r_hand.bank, r_step[ROW_W-1:0]};

    // Build the next result beat
    always_comb begin
        n_data = '0;
        if (r_step == STEP_SUMMARY) begin
            n_data.result_kind     = KIND_SUMMARY;
            n_data.access_point_id = r_hand.bssid;
            n_data.capability_word = r_hand.capability;
            n_data.radio_channel   = r_hand.channel;
            n_data.name_length     = r_hand.name_length;
            n_data.parse_status    = r_hand.status;
            n_data.frame_strength  = r_hand.strength;
        end else begin
            n_data.result_kind  = KIND_CHUNK;
            n_data.chunk_number = row;
            n_data.run_last     = (r_step == STEP_LAST);
            for (int j = 0; j < ROW_BYTES; j++) begin
                if (r_hand.valid[{row, LANE_W'(j)}]) begin
                    n_data.name_chunk[8*j +: 8] = i_rdata[8*j +: 8];
                end
            end
        end
    end

    // Advance the run and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= STEP_SUMMARY;
            r_valid <= 1'b0;
        end else begin
            if (i_hand.load) begin
                r_busy <= 1'b1;
                r_step <= STEP_SUMMARY;
            end else if (load) begin
                r_step <= r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Capture the frame summary and the result payload
    always_ff @(posedge i_clk) begin
        if (i_hand.load) begin
            r_hand <= i_hand;
        end
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hand.load |-> !r_busy)
        else $error("frame handed off while a run is still draining");

    a_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.run_last) |->
            (r_data.result_kind == KIND_CHUNK && r_data.chunk_number == 2'd3))
        else $error("run_last on a beat other than the final chunk");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(load && r_step == STEP_LAST))
        else $error("run ended before its final chunk was loaded");

endmodule

// ===== hw/rtl/beacon_element_parser_core.sv =====
// Beacon element parser.
// Input channel (i_valid/o_ready/i_data): one frame byte per beat, from
// offset 0, with the signal strength and a last-byte mark. Output channel
// (o_valid/i_ready/o_data): on each frame's last byte, a run of five beats,
// one summary and then SSID chunks 0 to 3, run_last on the final chunk.
// Throughput: one byte per cycle, bar a held-off last-byte beat. A run's
// first beat is loaded once the frame summary is registered, and waits
// while the last byte's read-modify-write to the SSID store lands; the four
// chunks follow one per cycle unless stalled, each one 64-bit store RAM row.
// The store RAM holds two banks, so the next frame streams in while a run
// drains. A last-byte beat is held off (o_ready low) while the previous
// frame's run has not yet been fully loaded into the output register.
// A stalled receiver holds the output register; input keeps flowing until
// the next last-byte beat. Reset empties the run and points at a new frame;
// per-byte valid flags mask stale RAM contents, so no clearing pass is run.
module beacon_element_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bep_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bep_pkg::t_out_beat o_data
);
    import bep_pkg::*;

    // Frame state
    logic [7:0]             r_offset;
    logic                   r_bank;
    logic [8:0]             r_start,    n_start;
    logic [7:0]             r_id,       n_id;
    logic [7:0]             r_len,      n_len;
    logic                   r_walk,     n_walk;
    logic [7:0]             r_name_len, n_name_len;
    logic [7:0]             r_channel,  n_channel;
    t_status                r_status,   n_status;
    logic [15:0]            r_cap,      n_cap;
    logic [47:0]            r_bssid,    n_bssid;
    logic signed [7:0]      r_strength, n_strength;
    logic [STORE_BYTES-1:0] r_valid,    n_valid;

    // Store write request for this byte
    logic                   st_we;
    logic [IDX_W-1:0]       st_idx;
    logic                   accept;
    logic                   first;
    logic [7:0]             b;
    logic [8:0]             off9;
    logic [8:0]             rel;
    logic [8:0]             rel_m2;

    // Read-modify-write stage and forwarding
    logic                   r_mrg_valid;
    logic [RAM_AW-1:0]      r_mrg_addr;
    logic [LANE_W-1:0]      r_mrg_lane;
    logic [7:0]             r_mrg_byte;
    logic                   r_fwd_valid;
    logic [RAM_AW-1:0]      r_fwd_addr;
    logic [ROW_BITS-1:0]    r_fwd_data;
    logic [ROW_BITS-1:0]    mrg_base;
    logic [ROW_BITS-1:0]    mrg_row;
    logic [ROW_BITS-1:0]    rdata_a;
    logic [ROW_BITS-1:0]    rdata_b;

    t_handoff               hand;
    t_ram_req               wr_req;
    t_ram_req               run_rd;
    logic                   run_busy;

    assign accept  = i_valid && o_ready;
    assign o_ready = !(run_busy && i_data.frame_end);
    assign first   = (r_offset == '0);
    assign b       = i_data.frame_byte;
    assign off9    = {1'b0, r_offset};

    // Apply one byte to the frame state
    always_comb begin
        n_start    = first ? ELEMENT_BASE : r_start;
        n_id       = first ? '0 : r_id;
        n_len      = first ? '0 : r_len;
        n_walk     = first ? 1'b0 : r_walk;
        n_name_len = first ? '0 : r_name_len;
        n_channel  = first ? '0 : r_channel;
        n_status   = first ? STATUS_OK : r_status;
        n_cap      = first ? '0 : r_cap;
        n_bssid    = first ? '0 : r_bssid;
        n_strength = first ? i_data.signal_strength : r_strength;
        n_valid    = first ? '0 : r_valid;
        st_we      = 1'b0;
        st_idx     = '0;

        if (off9 >= BSSID_FIRST && off9 <= BSSID_LAST) begin
            n_bssid = {n_bssid[39:0], b};
        end
        if (off9 == CAP_LOW) begin
            n_cap[7:0] = b;
        end
        if (off9 == CAP_HIGH) begin
            n_cap[15:8] = b;
        end
        if (off9 == ELEMENT_BASE) begin
            if (b == ID_SSID) begin
                n_walk = 1'b1;
            end else begin
                n_status = STATUS_NO_SSID_FIRST;
            end
        end

        rel    = off9 - n_start;
        rel_m2 = rel - 9'd2;

        // Walk the element list inside the window
        if (n_walk && off9 >= n_start && off9 < FRAME_WINDOW) begin
            if (rel == 9'd0) begin
                n_id = b;
            end else if (n_id == ID_CHANNEL) begin
                if (rel == 9'd2) begin
                    n_channel = b;
                    n_walk    = 1'b0;
                end
            end else begin
                if (rel == 9'd1) begin
                    n_len = b;
                    if (n_id == ID_SSID) begin
                        n_name_len = b;
                        if (b == '0) begin
                            n_valid = '0;
                        end else if (b > NAME_MAX) begin
                            n_status = STATUS_TOO_LONG;
                        end else begin
                            n_valid  = '0;
                            n_status = STATUS_OK;
                        end
                    end
                end else if (n_id == ID_SSID && n_len != '0 && n_len <= NAME_MAX
                             && rel_m2 < {1'b0, n_len}) begin
                    st_we  = 1'b1;
                    st_idx = rel_m2[IDX_W-1:0];
                end
                if (rel == {1'b0, n_len} + 9'd1) begin
                    n_start = n_start + {1'b0, n_len} + 9'd2;
                end
            end
        end

        if (st_we) begin
            n_valid[st_idx] = 1'b1;
        end
    end

    // Advance the byte offset and the bank, track pending writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_bank      <= 1'b0;
            r_mrg_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_data.frame_end) begin
                    r_offset <= '0;
                    r_bank   <= ~r_bank;
                end else if (r_offset != OFFSET_MAX) begin
                    r_offset <= r_offset + 8'd1;
                end
            end
            r_mrg_valid <= accept && st_we;
            if (r_mrg_valid) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Hold the frame state between beats
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start    <= n_start;
            r_id       <= n_id;
            r_len      <= n_len;
            r_walk     <= n_walk;
            r_name_len <= n_name_len;
            r_channel  <= n_channel;
            r_status   <= n_status;
            r_cap      <= n_cap;
            r_bssid    <= n_bssid;
            r_strength <= n_strength;
            r_valid    <= n_valid;
        end
        if (accept && st_we) begin
            r_mrg_addr <= {r_bank, st_idx[IDX_W-1:LANE_W]};
            r_mrg_lane <= st_idx[LANE_W-1:0];
            r_mrg_byte <= b;
        end
        if (r_mrg_valid) begin
            r_fwd_addr <= r_mrg_addr;
            r_fwd_data <= mrg_row;
        end
    end

    // Merge the byte into the row; forward the previous write to the same row
    always_comb begin
        mrg_base = (r_fwd_valid && r_fwd_addr == r_mrg_addr) ? r_fwd_data : rdata_a;
        mrg_row  = mrg_base;
        for (int j = 0; j < ROW_BYTES; j++) begin
            if (r_mrg_lane == LANE_W'(j)) begin
                mrg_row[8*j +: 8] = r_mrg_byte;
            end
        end
    end

    assign wr_req.en   = r_mrg_valid;
    assign wr_req.addr = r_mrg_addr;

    bep_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (r_mrg_valid),
        .i_waddr   (r_mrg_addr),
        .i_wdata   (mrg_row),
        .i_re_a    (accept && st_we),
        .i_raddr_a ({r_bank, st_idx[IDX_W-1:LANE_W]}),
        .o_rdata_a (rdata_a),
        .i_re_b    (run_rd.en),
        .i_raddr_b (run_rd.addr),
        .o_rdata_b (rdata_b)
    );

    // Hand the finished frame to the result sequencer
    assign hand.load        = accept && i_data.frame_end;
    assign hand.bank        = r_bank;
    assign hand.bssid       = n_bssid;
    assign hand.capability  = n_cap;
    assign hand.channel     = n_channel;
    assign hand.name_length = n_name_len;
    assign hand.status      = n_status;
    assign hand.strength    = n_strength;
    assign hand.valid       = n_valid;

    bep_run u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hand  (hand),
        .i_wr    (wr_req),
        .o_busy  (run_busy),
        .o_rd    (run_rd),
        .i_rdata (rdata_b),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.frame_end) |=> (r_offset == '0))
        else $error("byte offset not back at frame start after the last byte");

    a_merge_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mrg_valid |-> $past(accept))
        else $error("store write without an accepted byte");

    a_no_row_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mrg_valid && run_rd.en) |-> (r_mrg_addr != run_rd.addr))
        else $error("result read of a row that is being written");

endmodule
